@@ rtl/rme_pkg.sv @@
// ----------------------------------------------------------------------------
// rme_pkg: shared constants for the rational map escape-time block
// Port widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int IO_W       = 32;  // width of the point and multiplier fields
  localparam int LIM_W      = 10;  // width of the iteration limit and count
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MULT_RE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_IM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIM = 2'd2;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 10'd50;
  localparam int RADIUS_DIV = 100;

endpackage

@@ rtl/rme_point_if.sv @@
// ----------------------------------------------------------------------------
// rme_point_if: start point channel
// Valid/ready channel carrying one complex start point per transaction.
// ----------------------------------------------------------------------------
interface rme_point_if import rme_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] start_re;
  logic signed [IO_W-1:0] start_im;

  modport source (output valid, output start_re, output start_im, input ready);
  modport sink   (input valid, input start_re, input start_im, output ready);
endinterface

@@ rtl/rme_result_if.sv @@
// ----------------------------------------------------------------------------
// rme_result_if: result channel
// Valid/ready channel carrying the convergence flag and step count.
// ----------------------------------------------------------------------------
interface rme_result_if import rme_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             converged;
  logic [LIM_W-1:0] steps_taken;

  modport source (output valid, output converged, output steps_taken, input ready);
  modport sink   (input valid, input converged, input steps_taken, output ready);
endinterface

@@ rtl/rational_map_escape_time.sv @@
// ----------------------------------------------------------------------------
// rational_map_escape_time: escape-time iteration of a rational map
// Iterates p <- p(p-2+a)/(pa-1) in saturating fixed point on one shared
// multiplier and one serial divider, and reports convergence and step count.
// ----------------------------------------------------------------------------
// Usage: a start point enters on the point channel (valid/ready); one
// transaction on the result channel answers it. The multiplier a and the
// iteration limit are written through the write port while the block is idle.
// One point is in work at a time: point.ready is high only when idle.
// A step with a zero denominator skips both divisions. The radius test scales
// the distance by 100 rather than dividing, so no division is spent on it.
// The shared multiplier registers each product, and the bit-serial divider
// gives one quotient bit per cycle. After the result is taken the block
// returns to idle before it accepts the next point.
// Reset returns the block to idle, sets a = 1.0 and the limit to 50. A result
// is held in the output register until the receiver takes it, and no new point
// is taken before then.
// ----------------------------------------------------------------------------
module rational_map_escape_time import rme_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_en,
  input  logic [CFG_IDX_W-1:0]  write_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  rme_point_if.sink             point,
  rme_result_if.source          result
);

  localparam int WID = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
  localparam int FRB = (FRAC_BITS > WID - 4) ? WID - 4 : ((FRAC_BITS < 1) ? 1 : FRAC_BITS);
  localparam int PW  = 2 * WID;
  localparam int SW  = 2 * WID + 2;
  localparam int DVW = PW + FRB;
  localparam int DSW = PW + 7;

  localparam logic signed [SW-1:0] ONE_S  = SW'(1) << FRB;
  localparam logic signed [SW-1:0] VMAX_S = (SW'(1) << (WID - 1)) - SW'(1);
  localparam logic signed [SW-1:0] VMIN_S = -(SW'(1) << (WID - 1));

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_USE, S_DIV, S_OUT} state_t;
  typedef enum logic [4:0] {
    OP_ER2, OP_EI2, OP_XR2, OP_PI2,
    OP_N0, OP_N1, OP_N2, OP_N3,
    OP_M0, OP_M1, OP_M2, OP_M3,
    OP_D0, OP_D1, OP_Q0, OP_Q1, OP_Q2, OP_Q3
  } op_t;

  function automatic logic signed [SW-1:0] ext(input logic signed [WID-1:0] x);
    ext = {{(SW - WID){x[WID-1]}}, x};
  endfunction

  function automatic logic signed [WID-1:0] sat(input logic signed [SW-1:0] v);
    if (v > VMAX_S)      sat = VMAX_S[WID-1:0];
    else if (v < VMIN_S) sat = VMIN_S[WID-1:0];
    else                 sat = v[WID-1:0];
  endfunction

  function automatic logic signed [WID-1:0] sat_io(input logic [IO_W-1:0] x);
    sat_io = sat({{(SW - IO_W){x[IO_W-1]}}, x});
  endfunction

  state_t state;
  op_t    op;

  logic signed [WID-1:0] mult_re, mult_im;
  logic [LIM_W-1:0]      iteration_limit;
  logic signed [WID-1:0] pr, pi, nr, ni, mr, mi;
  logic signed [SW-1:0]  acc;
  logic [PW-1:0]         d2, radius;
  logic [LIM_W-1:0]      step_cnt;

  logic signed [WID-1:0] mul_a, mul_b;
  logic signed [PW-1:0]  prod, prod_sh;
  logic signed [SW-1:0]  pe, pf, sum_p, dif_p, sum_abs, dif_abs;
  logic signed [WID-1:0] er, ei, xr, tr, ti;
  logic [DSW-1:0]        dist_scaled;

  logic             div_start, div_frac, div_neg, div_busy, div_done;
  logic [PW-1:0]    div_num, div_den;
  logic [DVW-1:0]   div_quot;
  logic             q_big;
  logic [WID:0]     q_mag;
  logic signed [WID-1:0] q_res;

  assign er = sat(ONE_S - ext(mult_re));
  assign ei = sat(-ext(mult_im));
  assign xr = sat(ext(pr) - ONE_S);
  assign tr = sat(ext(pr) - (ONE_S <<< 1) + ext(mult_re));
  assign ti = sat(ext(pi) + ext(mult_im));

  always_comb begin
    case (op)
      OP_ER2:  begin mul_a = er; mul_b = er;      end
      OP_EI2:  begin mul_a = ei; mul_b = ei;      end
      OP_XR2:  begin mul_a = xr; mul_b = xr;      end
      OP_PI2:  begin mul_a = pi; mul_b = pi;      end
      OP_N0:   begin mul_a = pr; mul_b = tr;      end
      OP_N1:   begin mul_a = pi; mul_b = ti;      end
      OP_N2:   begin mul_a = pr; mul_b = ti;      end
      OP_N3:   begin mul_a = pi; mul_b = tr;      end
      OP_M0:   begin mul_a = pr; mul_b = mult_re; end
      OP_M1:   begin mul_a = pi; mul_b = mult_im; end
      OP_M2:   begin mul_a = pr; mul_b = mult_im; end
      OP_M3:   begin mul_a = pi; mul_b = mult_re; end
      OP_D0:   begin mul_a = mr; mul_b = mr;      end
      OP_D1:   begin mul_a = mi; mul_b = mi;      end
      OP_Q0:   begin mul_a = nr; mul_b = mr;      end
      OP_Q1:   begin mul_a = ni; mul_b = mi;      end
      OP_Q2:   begin mul_a = ni; mul_b = mr;      end
      OP_Q3:   begin mul_a = nr; mul_b = mi;      end
      default: begin mul_a = '0; mul_b = '0;      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);
  end

  // Full product and product rounded toward minus infinity to FRB bits.
  assign prod_sh = prod >>> FRB;
  assign pe      = {{(SW - PW){prod[PW-1]}}, prod};
  assign pf      = {{(SW - PW){prod_sh[PW-1]}}, prod_sh};
  assign sum_p   = acc + pe;
  assign dif_p   = acc - pe;
  assign sum_abs = sum_p[SW-1] ? -sum_p : sum_p;
  assign dif_abs = dif_p[SW-1] ? -dif_p : dif_p;

  // For a whole distance, dist <= floor(S / 100) holds exactly when
  // 100 * dist <= S, so the radius register keeps S itself.
  assign dist_scaled = DSW'(sum_p[PW-1:0]) * DSW'(RADIUS_DIV);

  // Quotient magnitude capped at 2^(WID-1); the cap is the minimum when negative.
  assign q_big = |div_quot[DVW-1:WID-1];
  assign q_mag = q_big ? ((WID + 1)'(1) << (WID - 1)) : {1'b0, div_quot[WID-1:0]};
  always_comb begin
    if (div_neg)    q_res = WID'(-q_mag);
    else if (q_big) q_res = VMAX_S[WID-1:0];
    else            q_res = div_quot[WID-1:0];
  end

  rme_div #(.NW(PW), .FW(FRB)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .frac  (div_frac),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mult_re         <= sat(ONE_S);
      mult_im         <= '0;
      iteration_limit <= LIMIT_RESET;
    end else if (write_en) begin
      case (write_index)
        CFG_MULT_RE:  mult_re         <= sat_io(write_data[IO_W-1:0]);
        CFG_MULT_IM:  mult_im         <= sat_io(write_data[IO_W-1:0]);
        CFG_ITER_LIM: iteration_limit <= write_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign point.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_ER2;
      div_start    <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (point.valid) begin
            pr       <= sat_io(point.start_re);
            pi       <= sat_io(point.start_im);
            step_cnt <= '0;
            op       <= OP_ER2;
            state    <= S_MUL;
          end
        end
        S_MUL: state <= S_USE;
        S_USE: begin
          state <= S_MUL;
          case (op)
            OP_ER2: begin acc <= pe; op <= OP_EI2; end
            OP_EI2: begin radius <= sum_p[PW-1:0]; op <= OP_XR2; end
            OP_XR2: begin acc <= pe; op <= OP_PI2; end
            OP_PI2: begin
              if (step_cnt >= iteration_limit || dist_scaled <= DSW'(radius)) begin
                result.valid       <= 1'b1;
                result.converged   <= step_cnt < iteration_limit;
                result.steps_taken <= (step_cnt < iteration_limit) ? step_cnt : '0;
                state              <= S_OUT;
              end else begin
                op <= OP_N0;
              end
            end
            OP_N0: begin acc <= pf; op <= OP_N1; end
            OP_N1: begin nr <= sat(acc - pf); op <= OP_N2; end
            OP_N2: begin acc <= pf; op <= OP_N3; end
            OP_N3: begin ni <= sat(acc + pf); op <= OP_M0; end
            OP_M0: begin acc <= pf; op <= OP_M1; end
            OP_M1: begin mr <= sat(ext(sat(acc - pf)) - ONE_S); op <= OP_M2; end
            OP_M2: begin acc <= pf; op <= OP_M3; end
            OP_M3: begin mi <= sat(acc + pf); op <= OP_D0; end
            OP_D0: begin acc <= pe; op <= OP_D1; end
            OP_D1: begin
              if (sum_p == '0) begin
                // Zero denominator: each part saturates by the numerator's sign.
                pr       <= nr[WID-1] ? VMIN_S[WID-1:0] : VMAX_S[WID-1:0];
                pi       <= ni[WID-1] ? VMIN_S[WID-1:0] : VMAX_S[WID-1:0];
                step_cnt <= step_cnt + 1'b1;
                op       <= OP_XR2;
              end else begin
                d2 <= sum_p[PW-1:0];
                op <= OP_Q0;
              end
            end
            OP_Q0: begin acc <= pe; op <= OP_Q1; end
            OP_Q1: begin
              div_num   <= sum_abs[PW-1:0];
              div_den   <= d2;
              div_frac  <= 1'b1;
              div_neg   <= sum_p[SW-1];
              div_start <= 1'b1;
              state     <= S_DIV;
            end
            OP_Q2: begin acc <= pe; op <= OP_Q3; end
            OP_Q3: begin
              div_num   <= dif_abs[PW-1:0];
              div_den   <= d2;
              div_frac  <= 1'b1;
              div_neg   <= dif_p[SW-1];
              div_start <= 1'b1;
              state     <= S_DIV;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
            case (op)
              OP_Q1:  begin pr <= q_res; op <= OP_Q2; end
              OP_Q3:  begin
                pi       <= q_res;
                step_cnt <= step_cnt + 1'b1;
                op       <= OP_XR2;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_OUT: begin
          if (result.ready) begin
            result.valid <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(point.ready && result.valid))
    else $error("new point taken while a result is pending");
  a_steps_conv: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.steps_taken != '0 |-> result.converged)
    else $error("non-zero step count without convergence");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_USE |-> step_cnt <= iteration_limit)
    else $error("step count passed the iteration limit");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_DIV)
    else $error("divider running outside the divide state");

endmodule

@@ rtl/rme_div.sv @@
// ----------------------------------------------------------------------------
// rme_div: restoring bit-serial divider
// Divides an unsigned numerator, optionally scaled up by FW fraction bits,
// by an unsigned non-zero denominator; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rme_div #(
  parameter int NW = 64,
  parameter int FW = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             frac,
  input  logic [NW-1:0]    num,
  input  logic [NW-1:0]    den,
  output logic             busy,
  output logic             done,
  output logic [NW+FW-1:0] quot
);

  localparam int DW = NW + FW;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dq;
  logic [NW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [NW:0]   trial;
  logic          ge;

  // The dividend bits leave at the top while quotient bits enter at the bottom.
  assign trial = {rem, dq[DW-1]};
  assign ge    = trial >= {1'b0, den};
  assign quot  = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        dq   <= frac ? {num, {FW{1'b0}}} : {{FW{1'b0}}, num};
        rem  <= '0;
        cnt  <= CW'(DW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? NW'(trial - {1'b0, den}) : trial[NW-1:0];
        dq  <= {dq[DW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with no steps left");

endmodule
